// File: sv/orb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Overwriting ring buffer package
// Shared widths, defaults, operation codes and the controller command bundle.
// ----------------------------------------------------------------------------
package orb_pkg;

    localparam int SLOTS_DEF        = 256;
    localparam int ELEMENT_BITS_DEF = 64;

    localparam int DATA_W = 64;
    localparam int IDX_W  = 8;
    localparam int FILL_W = 8;
    localparam int OVW_W  = 16;
    localparam int CAP_W  = 8;

    localparam logic [CAP_W-1:0] CAP_RESET = 8'd255;
    localparam logic [OVW_W-1:0] OVW_MAX   = 16'hFFFF;

    typedef enum logic [1:0] {
        FUNC_ADD    = 2'd0,
        FUNC_REMOVE = 2'd1,
        FUNC_PEEK   = 2'd2,
        FUNC_CLEAR  = 2'd3
    } t_func;

    typedef struct packed {
        logic op_accept;
        logic out_load;
        logic cfg_write;
    } t_dp_cmd;

endpackage
`default_nettype wire

// File: sv/orb_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Overwriting ring buffer controller
// Sequences each operation through its memory access and the result register.
// ----------------------------------------------------------------------------
module orb_ctrl
    import orb_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    input  wire logic i_cfg_valid,
    output logic      o_cfg_ready,
    output t_dp_cmd   o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_RESP
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_load;
    logic   in_ready;
    logic   accept;

    assign out_load = (r_state == S_RESP) && (!r_out_valid || i_out_ready);
    assign in_ready = (r_state == S_IDLE) || out_load;
    assign accept   = i_in_valid && in_ready;

    always_comb begin
        n_state = r_state;
        if (accept) begin
            n_state = S_RESP;
        end else if (out_load) begin
            n_state = S_IDLE;
        end
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready      = in_ready;
    assign o_out_valid     = r_out_valid;
    assign o_cfg_ready     = 1'b1;
    assign o_cmd.op_accept = accept;
    assign o_cmd.out_load  = out_load;
    assign o_cmd.cfg_write = i_cfg_valid;

endmodule
`default_nettype wire

// File: sv/orb_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Overwriting ring buffer datapath
// Holds the record memory, ring pointers, overwrite counter and result register.
// ----------------------------------------------------------------------------
module orb_dp
    import orb_pkg::*;
#(
    parameter int SLOTS        = SLOTS_DEF,
    parameter int ELEMENT_BITS = ELEMENT_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_dp_cmd           i_cmd,
    input  wire logic [1:0]        i_func,
    input  wire logic [DATA_W-1:0] i_data_in,
    input  wire logic [IDX_W-1:0]  i_peek_index,
    input  wire logic [CAP_W-1:0]  i_cfg_capacity,
    output logic [DATA_W-1:0]      o_data_out,
    output logic                   o_found,
    output logic [FILL_W-1:0]      o_fill_count,
    output logic [OVW_W-1:0]       o_overwrite_total
);

    localparam int PTR_W   = $clog2(SLOTS);
    localparam int CAP_MAX = (SLOTS - 1 < 255) ? SLOTS - 1 : 255;
    localparam int F_W     = PTR_W + 1;
    localparam int SUM_W   = ((PTR_W > IDX_W) ? PTR_W : IDX_W) + 1;
    localparam int FEXT_W  = (F_W > FILL_W) ? F_W : FILL_W;

    logic [ELEMENT_BITS-1:0] r_mem [SLOTS];
    logic [ELEMENT_BITS-1:0] r_rd_data;
    logic [PTR_W-1:0]        r_head;
    logic [PTR_W-1:0]        r_tail;
    logic [PTR_W-1:0]        r_cap_last;
    logic [OVW_W-1:0]        r_ovw;
    logic                    r_found;
    logic [PTR_W-1:0]        n_head;
    logic [PTR_W-1:0]        n_tail;
    logic [PTR_W-1:0]        n_cap_last;
    logic [OVW_W-1:0]        n_ovw;
    logic                    n_found;
    logic [DATA_W-1:0]       r_data_out;
    logic                    r_found_out;
    logic [FILL_W-1:0]       r_fill_out;
    logic [OVW_W-1:0]        r_ovw_out;

    t_func            func;
    logic [PTR_W-1:0] head_adv;
    logic [PTR_W-1:0] tail_adv;
    logic [F_W-1:0]   fill;
    logic [FEXT_W-1:0] fill_ext;
    logic [SUM_W-1:0] peek_sum;
    logic [SUM_W-1:0] ring_size;
    logic [SUM_W-1:0] peek_pos;
    logic             peek_hit;
    logic             not_empty;
    logic [PTR_W-1:0] rd_addr;
    logic             rd_en;
    logic             wr_en;

    assign func      = t_func'(i_func);
    assign head_adv  = (r_head == r_cap_last) ? '0 : r_head + 1'b1;
    assign tail_adv  = (r_tail == r_cap_last) ? '0 : r_tail + 1'b1;
    assign not_empty = (r_head != r_tail);

    always_comb begin
        if (r_head >= r_tail) begin
            fill = F_W'(r_head) - F_W'(r_tail);
        end else begin
            fill = F_W'(r_head) - F_W'(r_tail) + F_W'(r_cap_last) + 1'b1;
        end
    end

    assign fill_ext  = FEXT_W'(fill);
    assign ring_size = SUM_W'(r_cap_last) + 1'b1;
    assign peek_sum  = SUM_W'(r_tail) + SUM_W'(i_peek_index) + 1'b1;
    assign peek_pos  = (peek_sum >= ring_size) ? peek_sum - ring_size : peek_sum;
    assign peek_hit  = SUM_W'(i_peek_index) < SUM_W'(fill);

    always_comb begin
        if (int'(i_cfg_capacity) == 0) begin
            n_cap_last = PTR_W'(1);
        end else if (int'(i_cfg_capacity) > CAP_MAX) begin
            n_cap_last = PTR_W'(CAP_MAX);
        end else begin
            n_cap_last = PTR_W'(i_cfg_capacity);
        end
    end

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_ovw   = r_ovw;
        n_found = 1'b0;
        rd_addr = tail_adv;
        rd_en   = 1'b0;
        wr_en   = 1'b0;
        unique case (func)
            FUNC_ADD: begin
                n_head = head_adv;
                wr_en  = 1'b1;
                if (head_adv == r_tail) begin
                    n_tail = tail_adv;
                    if (r_ovw != OVW_MAX) begin
                        n_ovw = r_ovw + 1'b1;
                    end
                end
            end
            FUNC_REMOVE: begin
                if (not_empty) begin
                    n_tail  = tail_adv;
                    n_found = 1'b1;
                    rd_en   = 1'b1;
                end
            end
            FUNC_PEEK: begin
                rd_addr = peek_pos[PTR_W-1:0];
                if (peek_hit) begin
                    n_found = 1'b1;
                    rd_en   = 1'b1;
                end
            end
            FUNC_CLEAR: begin
                n_head = '0;
                n_tail = '0;
                n_ovw  = '0;
            end
            default: begin
                n_head = r_head;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head     <= '0;
            r_tail     <= '0;
            r_ovw      <= '0;
            r_cap_last <= PTR_W'(CAP_MAX);
        end else if (i_cmd.cfg_write) begin
            r_head     <= '0;
            r_tail     <= '0;
            r_ovw      <= '0;
            r_cap_last <= n_cap_last;
        end else if (i_cmd.op_accept) begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_ovw  <= n_ovw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op_accept && wr_en) begin
            r_mem[head_adv] <= i_data_in[ELEMENT_BITS-1:0];
        end
        if (i_cmd.op_accept && rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
        if (i_cmd.op_accept) begin
            r_found <= n_found;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_data_out  <= r_found ? DATA_W'(r_rd_data) : '0;
            r_found_out <= r_found;
            r_fill_out  <= fill_ext[FILL_W-1:0];
            r_ovw_out   <= r_ovw;
        end
    end

    assign o_data_out        = r_data_out;
    assign o_found           = r_found_out;
    assign o_fill_count      = r_fill_out;
    assign o_overwrite_total = r_ovw_out;

    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_head <= r_cap_last) && (r_tail <= r_cap_last))
        else $error("Ring pointer beyond the last ring slot.");

    a_fill_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> fill <= F_W'(r_cap_last))
        else $error("Fill count exceeds the configured capacity.");

    a_ovw_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_cmd.cfg_write && !(i_cmd.op_accept && func == FUNC_CLEAR))
        |=> r_ovw >= $past(r_ovw))
        else $error("Overwrite counter decreased without a clear.");

endmodule
`default_nettype wire

// File: sv/overwriting_ring_buffer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Overwriting ring buffer
// Ring of fixed-size records that drops the oldest record when full.
// ----------------------------------------------------------------------------
// Operations enter on the input channel (i_func, i_data_in, i_peek_index):
// add, remove oldest, peek at a position from the oldest, and clear. Each
// transfer yields exactly one result transfer on the output channel with the
// record (for remove and peek), a found flag, the fill count and the
// saturating overwrite count.
// The configuration channel writes the capacity (1 to 255 records, limited to
// SLOTS-1) and empties the buffer. Write it only while the block is idle.
// The memory read and pointer update happen at the input transfer edge, and
// the result register is loaded from them once it is free. A new operation
// is taken in the cycle its predecessor moves into the result register, so
// throughput is one operation per cycle while the receiver keeps up. When
// the receiver stalls, the result register holds and at most one further
// operation waits on its memory read, after which the input channel stalls.
// Reset empties the buffer, zeroes the overwrite count and sets the capacity
// to 255. The record memory is not cleared; only written entries are read.
// ----------------------------------------------------------------------------
module overwriting_ring_buffer
    import orb_pkg::*;
#(
    parameter int SLOTS        = SLOTS_DEF,
    parameter int ELEMENT_BITS = ELEMENT_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [1:0]        i_func,
    input  wire logic [DATA_W-1:0] i_data_in,
    input  wire logic [IDX_W-1:0]  i_peek_index,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic [DATA_W-1:0]      o_data_out,
    output logic                   o_found,
    output logic [FILL_W-1:0]      o_fill_count,
    output logic [OVW_W-1:0]       o_overwrite_total,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [CAP_W-1:0]  i_cfg_capacity
);

    t_dp_cmd cmd;

    orb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .o_cmd       (cmd)
    );

    orb_dp #(
        .SLOTS        (SLOTS),
        .ELEMENT_BITS (ELEMENT_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_func            (i_func),
        .i_data_in         (i_data_in),
        .i_peek_index      (i_peek_index),
        .i_cfg_capacity    (i_cfg_capacity),
        .o_data_out        (o_data_out),
        .o_found           (o_found),
        .o_fill_count      (o_fill_count),
        .o_overwrite_total (o_overwrite_total)
    );

endmodule
`default_nettype wire

// File: dv/tb_overwriting_ring_buffer.sv
// ----------------------------------------------------------------------------
// Overwriting ring buffer testbench
// Drives add, remove, peek and clear operations through the input channel and
// checks every result against a cycle-free prediction of the ring. A driver
// and a monitor run as clocked processes with random idle bursts on both
// sides. The run covers several capacities, overwrites at small and large
// capacities, and a receiver hold-off that fills the pipeline.
// ----------------------------------------------------------------------------
module tb_overwriting_ring_buffer
    import orb_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int unsigned RING_MAX    = 256;

    typedef struct packed {
        t_func             func;
        logic [DATA_W-1:0] data;
        logic [IDX_W-1:0]  idx;
    } t_ring_op;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              found;
        logic [FILL_W-1:0] fill;
        logic [OVW_W-1:0]  ovw;
    } t_ring_result;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    logic [1:0]        i_func = FUNC_ADD;
    logic [DATA_W-1:0] i_data_in = '0;
    logic [IDX_W-1:0]  i_peek_index = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic [DATA_W-1:0] o_data_out;
    logic              o_found;
    logic [FILL_W-1:0] o_fill_count;
    logic [OVW_W-1:0]  o_overwrite_total;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [CAP_W-1:0]  i_cfg_capacity = CAP_RESET;

    overwriting_ring_buffer u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_func            (i_func),
        .i_data_in         (i_data_in),
        .i_peek_index      (i_peek_index),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_data_out        (o_data_out),
        .o_found           (o_found),
        .o_fill_count      (o_fill_count),
        .o_overwrite_total (o_overwrite_total),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_capacity    (i_cfg_capacity)
    );

    always #5 i_clk = ~i_clk;

    t_ring_op     op_queue[$];
    t_ring_result awaited_results[$];
    t_ring_op     cur_op;
    t_ring_result head_want;

    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;
    bit          sender_gaps_on = 1'b1;
    bit          receiver_stalls_on = 1'b1;
    int unsigned gap_left = 0;
    int unsigned stall_left = 0;
    int unsigned hold_left = 0;
    int unsigned hold_len = 0;
    int unsigned hold_orders = 0;
    int unsigned hold_taken = 0;

    // Predicted ring state.
    logic [DATA_W-1:0] rec_mem [RING_MAX];
    int unsigned       head_ptr = 0;
    int unsigned       tail_ptr = 0;
    int unsigned       ovw_cnt = 0;
    int unsigned       cap_reg = CAP_RESET;

    function automatic int unsigned ring_len();
        int unsigned c;
        c = cap_reg;
        if (c < 1) c = 1;
        if (c > RING_MAX - 1) c = RING_MAX - 1;
        return c + 1;
    endfunction

    function automatic int unsigned step_slot(int unsigned p);
        return (p + 1 >= ring_len()) ? 0 : p + 1;
    endfunction

    function automatic int unsigned held_count();
        if (head_ptr >= tail_ptr) return head_ptr - tail_ptr;
        return ring_len() - tail_ptr + head_ptr;
    endfunction

    function automatic t_ring_result ring_outcome(t_ring_op op);
        t_ring_result r;
        int unsigned  p;
        r = '0;
        case (op.func)
            FUNC_ADD: begin
                head_ptr = step_slot(head_ptr);
                if (head_ptr == tail_ptr) begin
                    if (ovw_cnt < OVW_MAX) ovw_cnt++;
                    tail_ptr = step_slot(tail_ptr);
                end
                rec_mem[head_ptr] = op.data;
            end
            FUNC_REMOVE: begin
                if (tail_ptr != head_ptr) begin
                    tail_ptr = step_slot(tail_ptr);
                    r.data = rec_mem[tail_ptr];
                    r.found = 1'b1;
                end
            end
            FUNC_PEEK: begin
                if (op.idx < held_count()) begin
                    p = (tail_ptr + 1 + op.idx) % ring_len();
                    r.data = rec_mem[p];
                    r.found = 1'b1;
                end
            end
            default: begin
                head_ptr = 0;
                tail_ptr = 0;
                ovw_cnt = 0;
            end
        endcase
        r.fill = FILL_W'(held_count());
        r.ovw = OVW_W'(ovw_cnt);
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [DATA_W-1:0] got,
                                   logic [DATA_W-1:0] want);
        mismatch_count++;
        if (mismatch_count <= 100) begin
            $display("MISMATCH %s: got %h, expected %h at %0t", field, got, want, $realtime);
        end
    endtask

    // Driver: presents queued operations and predicts each accepted one.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            gap_left = 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                awaited_results.push_back(ring_outcome(cur_op));
            end
            if (!i_in_valid || o_in_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (sender_gaps_on && $urandom_range(0, 7) == 0) begin
                    gap_left = $urandom_range(0, 18);
                    i_in_valid <= 1'b0;
                end else if (op_queue.size() > 0) begin
                    cur_op = op_queue.pop_front();
                    i_in_valid <= 1'b1;
                    i_func <= cur_op.func;
                    i_data_in <= cur_op.data;
                    i_peek_index <= cur_op.idx;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result transfer and paces the receiver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (awaited_results.size() == 0) begin
                    report_mismatch("unexpected result", o_data_out, '0);
                end else begin
                    head_want = awaited_results.pop_front();
                    if (o_data_out !== head_want.data)
                        report_mismatch("data_out", o_data_out, head_want.data);
                    if (o_found !== head_want.found)
                        report_mismatch("found", DATA_W'(o_found),
                                        DATA_W'(head_want.found));
                    if (o_fill_count !== head_want.fill)
                        report_mismatch("fill_count", DATA_W'(o_fill_count),
                                        DATA_W'(head_want.fill));
                    if (o_overwrite_total !== head_want.ovw)
                        report_mismatch("overwrite_total", DATA_W'(o_overwrite_total),
                                        DATA_W'(head_want.ovw));
                end
            end
            if (hold_orders != hold_taken) begin
                hold_taken = hold_orders;
                hold_left = hold_len;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else if (receiver_stalls_on && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(0, 18);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic push_op(t_func f, logic [DATA_W-1:0] d, logic [IDX_W-1:0] idx);
        t_ring_op op;
        op.func = f;
        op.data = d;
        op.idx = idx;
        op_queue.push_back(op);
    endtask

    function automatic logic [DATA_W-1:0] any_record();
        case ($urandom_range(0, 9))
            0: return '1;
            1: return '0;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic wait_drained();
        do @(negedge i_clk);
        while (op_queue.size() != 0 || i_in_valid || awaited_results.size() != 0);
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_capacity <= value;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cap_reg = 32'(value);
        head_ptr = 0;
        tail_ptr = 0;
        ovw_cnt = 0;
        @(negedge i_clk);
    endtask

    task automatic run_random_phase(logic [CAP_W-1:0] cap, int n);
        int unsigned pick;
        int unsigned eff;
        wait_drained();
        write_capacity(cap);
        eff = (cap == 0) ? 1 : 32'(cap);
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                push_op(FUNC_ADD, any_record(), IDX_W'($urandom_range(0, 255)));
            else if (pick < 70)
                push_op(FUNC_REMOVE, any_record(), IDX_W'($urandom_range(0, 255)));
            else if (pick < 96)
                push_op(FUNC_PEEK, any_record(),
                        ($urandom_range(0, 4) == 0) ? IDX_W'($urandom_range(0, 255))
                                                    : IDX_W'($urandom_range(0, eff)));
            else
                push_op(FUNC_CLEAR, any_record(), IDX_W'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset capacity: empty cases, extremes of the record and the index.
        push_op(FUNC_REMOVE, '0, '0);
        push_op(FUNC_PEEK, '0, 8'd0);
        push_op(FUNC_ADD, '1, '1);
        push_op(FUNC_ADD, '0, '0);
        push_op(FUNC_ADD, 64'hA5A5_A5A5_A5A5_A5A5, 8'h55);
        push_op(FUNC_ADD, 64'h5A5A_5A5A_5A5A_5A5A, 8'hAA);
        push_op(FUNC_PEEK, '0, 8'd0);
        push_op(FUNC_PEEK, '0, 8'd3);
        push_op(FUNC_PEEK, '0, 8'd4);
        push_op(FUNC_PEEK, '0, 8'd255);
        push_op(FUNC_REMOVE, '1, '0);
        push_op(FUNC_REMOVE, '0, '0);
        push_op(FUNC_CLEAR, '1, '1);
        push_op(FUNC_REMOVE, '0, '0);

        // Smallest capacity: every add past the first overwrites.
        wait_drained();
        write_capacity(8'd1);
        push_op(FUNC_ADD, 64'h0123_4567_89AB_CDEF, '0);
        push_op(FUNC_ADD, 64'hFEDC_BA98_7654_3210, '0);
        push_op(FUNC_ADD, '1, '0);
        push_op(FUNC_PEEK, '0, 8'd0);
        push_op(FUNC_PEEK, '0, 8'd1);
        push_op(FUNC_REMOVE, '0, '0);
        push_op(FUNC_REMOVE, '0, '0);
        push_op(FUNC_CLEAR, '0, '0);

        // A capacity of zero behaves as a capacity of one.
        wait_drained();
        write_capacity(8'd0);
        push_op(FUNC_ADD, 64'h1111_2222_3333_4444, '0);
        push_op(FUNC_ADD, 64'h5555_6666_7777_8888, '0);
        push_op(FUNC_PEEK, '0, 8'd0);
        push_op(FUNC_REMOVE, '0, '0);

        // Largest capacity filled past the top while the receiver holds off.
        wait_drained();
        write_capacity(8'd255);
        hold_len = 400;
        hold_orders++;
        for (int k = 0; k < 260; k++) push_op(FUNC_ADD, {$urandom, $urandom}, '0);
        push_op(FUNC_PEEK, '0, 8'd0);
        push_op(FUNC_PEEK, '0, 8'd254);
        push_op(FUNC_PEEK, '0, 8'd255);
        for (int k = 0; k < 30; k++)
            push_op(FUNC_PEEK, '0, IDX_W'($urandom_range(0, 255)));
        push_op(FUNC_REMOVE, '0, '0);
        push_op(FUNC_PEEK, '0, 8'd254);
        push_op(FUNC_PEEK, '0, 8'd253);
        push_op(FUNC_ADD, {$urandom, $urandom}, '0);
        push_op(FUNC_PEEK, '0, 8'd254);

        run_random_phase(8'd2, 20);
        run_random_phase(8'd254, 20);
        run_random_phase(CAP_W'($urandom_range(3, 20)), 20);
        run_random_phase(CAP_W'($urandom_range(1, 255)), 20);
        run_random_phase(8'd3, 20);
        wait_drained();
        sender_gaps_on = 1'b0;
        receiver_stalls_on = 1'b0;
        run_random_phase(CAP_W'($urandom_range(1, 8)), 20);

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0 && awaited_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// File: sim.f
sv/orb_pkg.sv
sv/orb_ctrl.sv
sv/orb_dp.sv
sv/overwriting_ring_buffer.sv
dv/tb_overwriting_ring_buffer.sv
